FILE: design/ctht_pkg.sv
// ctht_pkg: shared types, widths and codes of the chained hash table engine.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package ctht_pkg;

	localparam int POOL_DEPTH = 1024;
	localparam int ADDR_W     = 10;
	localparam int IDX_W      = 11;
	localparam int KEY_W      = 32;
	localparam int DATA_W     = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [DATA_W-1:0] data_t;

	localparam idx_t END_MARK   = idx_t'(POOL_DEPTH);
	localparam idx_t MIN_SIZE   = idx_t'(7);
	localparam idx_t RESET_SIZE = idx_t'(797);

	localparam logic [1:0] MODE_GET    = 2'd0;
	localparam logic [1:0] MODE_PUT    = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_CHANGE = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_ZERO_DATA = 2'd3;

	typedef struct packed {
		logic  start;
		key_t  dividend;
		idx_t  divisor;
	} mod_req_t;

	typedef struct packed {
		logic  done;
		idx_t  rem;
	} mod_rsp_t;

	typedef struct packed {
		logic [1:0] status;
		data_t      data_out;
		idx_t       used_count;
	} rsp_t;

endpackage
`default_nettype wire

FILE: design/ctht_req_if.sv
// ctht_req_if: request channel (valid/ready plus request word).
// Depends on ctht_pkg.
`default_nettype none
interface ctht_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	ctht_pkg::key_t     key;
	ctht_pkg::data_t    data_in;

	modport source (output valid, mode, key, data_in, input ready);
	modport sink   (input valid, mode, key, data_in, output ready);
endinterface
`default_nettype wire

FILE: design/ctht_rsp_if.sv
// ctht_rsp_if: response channel (valid/ready plus result word).
// Depends on ctht_pkg.
`default_nettype none
interface ctht_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	ctht_pkg::data_t    data_out;
	ctht_pkg::idx_t     used_count;

	modport source (output valid, status, data_out, used_count, input ready);
	modport sink   (input valid, status, data_out, used_count, output ready);
endinterface
`default_nettype wire

FILE: design/ctht_cfg_if.sv
// ctht_cfg_if: configuration write channel carrying table_size.
// Depends on ctht_pkg.
`default_nettype none
interface ctht_cfg_if;
	logic               valid;
	logic               ready;
	ctht_pkg::idx_t     table_size;

	modport source (output valid, table_size, input ready);
	modport sink   (input valid, table_size, output ready);
endinterface
`default_nettype wire

FILE: design/ctht_mod.sv
// ctht_mod: iterative restoring modulo, one key bit per cycle.
// Depends on ctht_pkg.
`default_nettype none
module ctht_mod (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctht_pkg::mod_req_t  req,
	output ctht_pkg::mod_rsp_t       rsp
);

	localparam int CNT_W = $clog2(ctht_pkg::KEY_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	ctht_pkg::key_t      sh_q;
	ctht_pkg::idx_t      rem_q;
	ctht_pkg::idx_t      div_q;
	logic [ctht_pkg::IDX_W:0] trial;
	logic [ctht_pkg::IDX_W:0] nxt;

	always_comb begin
		trial = {1'b0, rem_q[ctht_pkg::IDX_W-2:0], sh_q[ctht_pkg::KEY_W-1]};
		if (trial >= {1'b0, div_q})
			nxt = trial - {1'b0, div_q};
		else
			nxt = trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sh_q   <= '0;
			rem_q  <= '0;
			div_q  <= ctht_pkg::MIN_SIZE;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				sh_q   <= req.dividend;
				rem_q  <= '0;
				div_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= nxt[ctht_pkg::IDX_W-1:0];
				sh_q  <= {sh_q[ctht_pkg::KEY_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ctht_pkg::KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

FILE: design/ctht_core.sv
// ctht_core: request sequencer and the bucket/entry memories of the table.
// Depends on ctht_pkg, ctht_req_if and ctht_mod.
`default_nettype none
module ctht_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            init,
	input  wire ctht_pkg::idx_t  size,
	ctht_req_if.sink             req,
	output ctht_pkg::rsp_t       rsp_data,
	output logic                 rsp_valid,
	input  wire logic            rsp_take
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MOD   = 4'd2;
	localparam logic [3:0] S_HRD   = 4'd3;
	localparam logic [3:0] S_HGET  = 4'd4;
	localparam logic [3:0] S_PUT_A = 4'd5;
	localparam logic [3:0] S_PUT_B = 4'd6;
	localparam logic [3:0] S_W_ISS = 4'd7;
	localparam logic [3:0] S_W_CHK = 4'd8;
	localparam logic [3:0] S_REM_A = 4'd9;
	localparam logic [3:0] S_REM_B = 4'd10;
	localparam logic [3:0] S_RSP   = 4'd11;

	logic [3:0]        state_q;
	ctht_pkg::addr_t   clr_q;
	logic [1:0]        mode_q;
	ctht_pkg::key_t    key_q;
	ctht_pkg::data_t   din_q;
	ctht_pkg::addr_t   b_q;
	ctht_pkg::idx_t    cur_q;
	ctht_pkg::idx_t    pos_q;
	ctht_pkg::idx_t    h_q;
	ctht_pkg::idx_t    prv_q;
	ctht_pkg::idx_t    nxt_q;
	ctht_pkg::idx_t    free_head_q;
	ctht_pkg::idx_t    fresh_q;
	ctht_pkg::idx_t    occ_q;
	ctht_pkg::rsp_t    rsp_q;

	ctht_pkg::mod_req_t mod_req;
	ctht_pkg::mod_rsp_t mod_rsp;

	// memories
	ctht_pkg::idx_t  head_mem [ctht_pkg::POOL_DEPTH];
	ctht_pkg::idx_t  next_mem [ctht_pkg::POOL_DEPTH];
	ctht_pkg::idx_t  prev_mem [ctht_pkg::POOL_DEPTH];
	ctht_pkg::key_t  key_mem  [ctht_pkg::POOL_DEPTH];
	ctht_pkg::data_t data_mem [ctht_pkg::POOL_DEPTH];

	ctht_pkg::idx_t  head_rd_q, next_rd_q, prev_rd_q;
	ctht_pkg::key_t  key_rd_q;
	ctht_pkg::data_t data_rd_q;

	logic            head_we, next_we, prev_we, key_we, data_we;
	ctht_pkg::addr_t head_wa, next_wa, prev_wa, next_ra;
	ctht_pkg::idx_t  head_wd, next_wd, prev_wd;
	ctht_pkg::data_t data_wd;

	logic            accept;
	logic            is_fresh;
	ctht_pkg::idx_t  pos_inc;
	ctht_pkg::idx_t  free_nxt;
	logic            hit;

	ctht_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign mod_req.start    = accept && !(req.mode == ctht_pkg::MODE_PUT &&
		(req.data_in == '0 || free_head_q == ctht_pkg::END_MARK));
	assign mod_req.dividend = req.key;
	assign mod_req.divisor  = size;

	// entries at or above fresh_q were never taken: their free link is implicit
	assign is_fresh = (free_head_q >= fresh_q);
	assign pos_inc  = free_head_q + ctht_pkg::idx_t'(1);
	assign free_nxt = is_fresh ? ((pos_inc < size) ? pos_inc : ctht_pkg::END_MARK)
		: next_rd_q;
	assign hit      = (key_rd_q == key_q);
	assign next_ra  = (state_q == S_HRD) ? free_head_q[ctht_pkg::ADDR_W-1:0]
		: cur_q[ctht_pkg::ADDR_W-1:0];

	always_comb begin
		head_we = 1'b0; head_wa = b_q; head_wd = ctht_pkg::END_MARK;
		next_we = 1'b0; next_wa = '0;  next_wd = ctht_pkg::END_MARK;
		prev_we = 1'b0; prev_wa = '0;  prev_wd = ctht_pkg::END_MARK;
		key_we  = 1'b0;
		data_we = 1'b0; data_wd = din_q;
		case (state_q)
			S_CLR: begin
				head_we = 1'b1;
				head_wa = clr_q;
			end
			S_PUT_A: begin
				head_we = 1'b1;
				head_wd = free_head_q;
				next_we = 1'b1;
				next_wa = free_head_q[ctht_pkg::ADDR_W-1:0];
				next_wd = head_rd_q;
				prev_we = 1'b1;
				prev_wa = free_head_q[ctht_pkg::ADDR_W-1:0];
				key_we  = 1'b1;
				data_we = 1'b1;
			end
			S_PUT_B: begin
				prev_we = (h_q != ctht_pkg::END_MARK);
				prev_wa = h_q[ctht_pkg::ADDR_W-1:0];
				prev_wd = pos_q;
			end
			S_W_CHK: begin
				data_we = hit && (mode_q == ctht_pkg::MODE_CHANGE);
			end
			S_REM_A: begin
				// unlink: predecessor (or bucket head) skips over, successor points back
				if (prv_q != ctht_pkg::END_MARK) begin
					next_we = 1'b1;
					next_wa = prv_q[ctht_pkg::ADDR_W-1:0];
					next_wd = nxt_q;
				end else begin
					head_we = 1'b1;
					head_wd = nxt_q;
				end
				prev_we = (nxt_q != ctht_pkg::END_MARK);
				prev_wa = nxt_q[ctht_pkg::ADDR_W-1:0];
				prev_wd = prv_q;
			end
			S_REM_B: begin
				next_we = 1'b1;
				next_wa = cur_q[ctht_pkg::ADDR_W-1:0];
				next_wd = free_head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[b_q];
	end

	always_ff @(posedge clk) begin
		if (next_we)
			next_mem[next_wa] <= next_wd;
		next_rd_q <= next_mem[next_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we)
			prev_mem[prev_wa] <= prev_wd;
		prev_rd_q <= prev_mem[cur_q[ctht_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[free_head_q[ctht_pkg::ADDR_W-1:0]] <= key_q;
		key_rd_q <= key_mem[cur_q[ctht_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (data_we)
			data_mem[(state_q == S_PUT_A) ? free_head_q[ctht_pkg::ADDR_W-1:0]
				: cur_q[ctht_pkg::ADDR_W-1:0]] <= data_wd;
		data_rd_q <= data_mem[cur_q[ctht_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			occ_q       <= '0;
			mode_q      <= ctht_pkg::MODE_GET;
			key_q       <= '0;
			din_q       <= '0;
			b_q         <= '0;
			cur_q       <= '0;
			pos_q       <= '0;
			h_q         <= '0;
			prv_q       <= '0;
			nxt_q       <= '0;
			rsp_q       <= '0;
		end else if (init) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			occ_q       <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ctht_pkg::addr_t'(ctht_pkg::POOL_DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						mode_q <= req.mode;
						key_q  <= req.key;
						din_q  <= req.data_in;
						rsp_q.data_out   <= '0;
						rsp_q.used_count <= occ_q;
						if (req.mode == ctht_pkg::MODE_PUT && req.data_in == '0) begin
							rsp_q.status <= ctht_pkg::ST_ZERO_DATA;
							state_q      <= S_RSP;
						end else if (req.mode == ctht_pkg::MODE_PUT &&
								free_head_q == ctht_pkg::END_MARK) begin
							rsp_q.status <= ctht_pkg::ST_FULL;
							state_q      <= S_RSP;
						end else begin
							rsp_q.status <= ctht_pkg::ST_OK;
							state_q      <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (mod_rsp.done) begin
						b_q     <= mod_rsp.rem[ctht_pkg::ADDR_W-1:0];
						state_q <= S_HRD;
					end
				end
				S_HRD: begin
					state_q <= (mode_q == ctht_pkg::MODE_PUT) ? S_PUT_A : S_HGET;
				end
				S_HGET: begin
					cur_q   <= head_rd_q;
					state_q <= S_W_ISS;
				end
				S_PUT_A: begin
					pos_q       <= free_head_q;
					h_q         <= head_rd_q;
					free_head_q <= free_nxt;
					if (is_fresh)
						fresh_q <= pos_inc;
					state_q     <= S_PUT_B;
				end
				S_PUT_B: begin
					occ_q            <= occ_q + 1'b1;
					rsp_q.used_count <= occ_q + 1'b1;
					state_q          <= S_RSP;
				end
				S_W_ISS: begin
					if (cur_q == ctht_pkg::END_MARK) begin
						rsp_q.status <= ctht_pkg::ST_NOT_FOUND;
						state_q      <= S_RSP;
					end else begin
						state_q <= S_W_CHK;
					end
				end
				S_W_CHK: begin
					if (hit) begin
						rsp_q.data_out <= data_rd_q;
						prv_q          <= prev_rd_q;
						nxt_q          <= next_rd_q;
						state_q <= (mode_q == ctht_pkg::MODE_REMOVE) ? S_REM_A : S_RSP;
					end else begin
						cur_q   <= next_rd_q;
						state_q <= S_W_ISS;
					end
				end
				S_REM_A: begin
					state_q <= S_REM_B;
				end
				S_REM_B: begin
					free_head_q <= cur_q;
					if (occ_q != '0) begin
						occ_q            <= occ_q - 1'b1;
						rsp_q.used_count <= occ_q - 1'b1;
					end
					state_q <= S_RSP;
				end
				S_RSP: begin
					if (rsp_take)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = (state_q == S_RSP);
	assign rsp_data  = rsp_q;

endmodule
`default_nettype wire

FILE: design/chained_hash_table_engine.sv
// Chained hash table engine: size register, result register and assertions.
// Depends on ctht_pkg, the three channel interfaces and ctht_core.
`default_nettype none
// A request word is taken one at a time. The bucket comes from a bit-serial
// modulo of the key by table_size; a refused put (zero data or full pool)
// skips it and goes straight to the result. Get, change and remove then walk
// the bucket's chain, each step of the walk being one read of the entry
// memories and one compare; a remove then relinks the entry's neighbours.
// The result sits in an output register, so the next request is taken while it
// waits. After reset and after every table_size write the bucket-head memory is
// swept, during which no request is taken. table_size values below 7 act as 7
// and above 1024 as 1024.
module chained_hash_table_engine (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ctht_req_if.sink   req,
	ctht_rsp_if.source rsp,
	ctht_cfg_if.sink   cfg
);

	ctht_pkg::idx_t  size_q;
	ctht_pkg::idx_t  size_act;
	logic            cfg_fire;
	ctht_pkg::rsp_t  core_rsp;
	logic            core_valid;
	logic            core_take;
	logic            out_valid_q;
	ctht_pkg::rsp_t  out_q;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= ctht_pkg::RESET_SIZE;
		else if (cfg_fire)
			size_q <= cfg.table_size;
	end

	always_comb begin
		if (size_q < ctht_pkg::MIN_SIZE)
			size_act = ctht_pkg::MIN_SIZE;
		else if (size_q > ctht_pkg::END_MARK)
			size_act = ctht_pkg::END_MARK;
		else
			size_act = size_q;
	end

	ctht_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (cfg_fire),
		.size      (size_act),
		.req       (req),
		.rsp_data  (core_rsp),
		.rsp_valid (core_valid),
		.rsp_take  (core_take)
	);

	assign core_take = core_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (core_take) begin
				out_valid_q <= 1'b1;
				out_q       <= core_rsp;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_q.status;
	assign rsp.data_out   = out_q.data_out;
	assign rsp.used_count = out_q.used_count;

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while one is in progress");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> !req.ready)
		else $error("request taken during table clear");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.used_count <= ctht_pkg::END_MARK))
		else $error("used count beyond pool depth");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ctht_pkg::ST_OK) |-> (rsp.data_out == '0))
		else $error("nonzero data on a failed request");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_chained_hash_table_engine.sv
// Testbench for chained_hash_table_engine: directed and random get/put/remove/change
// traffic checked against an in-bench model of the chained table.
// Depends on ctht_pkg, ctht_req_if, ctht_rsp_if, ctht_cfg_if and the engine RTL.
`timescale 1ns / 1ps
module tb_chained_hash_table_engine;

	localparam int WATCH_LIMIT = 40000;

	typedef struct packed {
		logic [1:0]      status;
		ctht_pkg::data_t data_out;
		ctht_pkg::idx_t  used_count;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ctht_req_if req ();
	ctht_rsp_if rsp ();
	ctht_cfg_if cfg ();

	chained_hash_table_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow table
	int unsigned     chain_head [ctht_pkg::POOL_DEPTH];
	int unsigned     chain_len  [ctht_pkg::POOL_DEPTH];
	int unsigned     link_next  [ctht_pkg::POOL_DEPTH];
	int unsigned     link_prev  [ctht_pkg::POOL_DEPTH];
	ctht_pkg::key_t  slot_key   [ctht_pkg::POOL_DEPTH];
	ctht_pkg::data_t slot_data  [ctht_pkg::POOL_DEPTH];
	int unsigned free_slot;
	int unsigned live_count;
	int unsigned eff_size;

	result_t        pending_results [$];
	ctht_pkg::key_t known_keys [$];

	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int full_hits = 0;
	int miss_hits = 0;
	bit idle_on = 1'b1;
	int hold_cycles = 0;
	int idle_left = 0;
	int quiet_cycles = 0;

	function automatic void rebuild_table(ctht_pkg::idx_t sz);
		int unsigned n;
		n = sz;
		if (n < ctht_pkg::MIN_SIZE) n = ctht_pkg::MIN_SIZE;
		if (n > ctht_pkg::POOL_DEPTH) n = ctht_pkg::POOL_DEPTH;
		eff_size = n;
		for (int i = 0; i < ctht_pkg::POOL_DEPTH; i++) begin
			chain_head[i] = ctht_pkg::POOL_DEPTH;
			chain_len[i] = 0;
			link_next[i] = (i + 1 < n) ? i + 1 : ctht_pkg::POOL_DEPTH;
			link_prev[i] = (i > 0 && i < n) ? i - 1 : ctht_pkg::POOL_DEPTH;
			slot_key[i] = '1;
			slot_data[i] = '0;
		end
		free_slot = 0;
		live_count = 0;
	endfunction

	function automatic result_t apply_request(logic [1:0] mode, ctht_pkg::key_t key,
			ctht_pkg::data_t din);
		result_t r;
		int unsigned b, pos, nxt, prv, idx, steps;
		r = '0;
		b = key % eff_size;
		if (mode == ctht_pkg::MODE_PUT) begin
			if (din == '0) begin
				r.status = ctht_pkg::ST_ZERO_DATA;
			end else if (free_slot >= ctht_pkg::POOL_DEPTH) begin
				r.status = ctht_pkg::ST_FULL;
			end else begin
				pos = free_slot;
				nxt = link_next[pos];
				if (nxt < ctht_pkg::POOL_DEPTH) link_prev[nxt] = ctht_pkg::POOL_DEPTH;
				free_slot = nxt;
				if (chain_head[b] < ctht_pkg::POOL_DEPTH) link_prev[chain_head[b]] = pos;
				link_next[pos] = chain_head[b];
				link_prev[pos] = ctht_pkg::POOL_DEPTH;
				slot_key[pos] = key;
				slot_data[pos] = din;
				chain_head[b] = pos;
				chain_len[b] = (chain_len[b] + 1) & 11'h7FF;
				live_count++;
			end
		end else begin
			pos = ctht_pkg::POOL_DEPTH;
			idx = chain_head[b];
			steps = 0;
			while (idx < ctht_pkg::POOL_DEPTH && steps <= chain_len[b]) begin
				if (slot_key[idx] == key) begin
					pos = idx;
					break;
				end
				idx = link_next[idx];
				steps++;
			end
			if (pos >= ctht_pkg::POOL_DEPTH) begin
				r.status = ctht_pkg::ST_NOT_FOUND;
			end else begin
				r.data_out = slot_data[pos];
				if (mode == ctht_pkg::MODE_CHANGE) begin
					slot_data[pos] = din;
				end else if (mode == ctht_pkg::MODE_REMOVE) begin
					prv = link_prev[pos];
					nxt = link_next[pos];
					if (prv < ctht_pkg::POOL_DEPTH) link_next[prv] = nxt;
					else chain_head[b] = nxt;
					if (nxt < ctht_pkg::POOL_DEPTH) link_prev[nxt] = prv;
					if (free_slot < ctht_pkg::POOL_DEPTH) link_prev[free_slot] = pos;
					link_next[pos] = free_slot;
					link_prev[pos] = ctht_pkg::POOL_DEPTH;
					slot_key[pos] = '1;
					slot_data[pos] = '0;
					free_slot = pos;
					if (live_count > 0) live_count--;
					if (chain_len[b] > 0) chain_len[b]--;
				end
			end
		end
		r.used_count = ctht_pkg::idx_t'(live_count);
		return r;
	endfunction

	task automatic send_request(logic [1:0] mode, ctht_pkg::key_t key,
			ctht_pkg::data_t din);
		req.valid <= 1'b1;
		req.mode <= mode;
		req.key <= key;
		req.data_in <= din;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(apply_request(mode, key, din));
		items_sent++;
		if (mode == ctht_pkg::MODE_PUT && din != '0) begin
			known_keys.push_back(key);
			if (known_keys.size() > 48) void'(known_keys.pop_front());
		end
	endtask

	task automatic sender_gap();
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 5);
			req.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_size(ctht_pkg::idx_t sz);
		drain_results();
		cfg.valid <= 1'b1;
		cfg.table_size <= sz;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		rebuild_table(sz);
	endtask

	function automatic ctht_pkg::key_t pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6 && known_keys.size() != 0)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		if (sel < 8)
			return ctht_pkg::key_t'($urandom_range(0, 3) * eff_size + $urandom_range(0, 5));
		return ctht_pkg::key_t'($urandom);
	endfunction

	task automatic random_traffic(int count);
		logic [1:0] mode;
		int sel;
		ctht_pkg::data_t din;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 38) mode = ctht_pkg::MODE_PUT;
			else if (sel < 62) mode = ctht_pkg::MODE_GET;
			else if (sel < 84) mode = ctht_pkg::MODE_REMOVE;
			else mode = ctht_pkg::MODE_CHANGE;
			din = ($urandom_range(0, 19) == 0) ? ctht_pkg::data_t'(0)
				: ctht_pkg::data_t'($urandom);
			send_request(mode, pick_key(), din);
			sender_gap();
		end
	endtask

	task automatic test_reset_size();
		random_traffic(370);
	endtask

	task automatic test_directed();
		write_size(ctht_pkg::idx_t'(0));
		send_request(ctht_pkg::MODE_GET, 32'd0, 32'd0);
		send_request(ctht_pkg::MODE_PUT, 32'd5, 32'd0);
		send_request(ctht_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ctht_pkg::MODE_PUT, 32'd0, 32'h1);
		send_request(ctht_pkg::MODE_PUT, 32'd7, 32'h8000_0000);
		send_request(ctht_pkg::MODE_PUT, 32'd14, 32'h55AA_55AA);
		send_request(ctht_pkg::MODE_PUT, 32'd7, 32'h1234_5678);
		send_request(ctht_pkg::MODE_GET, 32'd7, 32'd0);
		send_request(ctht_pkg::MODE_CHANGE, 32'd7, 32'd0);
		send_request(ctht_pkg::MODE_GET, 32'd7, 32'd0);
		send_request(ctht_pkg::MODE_REMOVE, 32'd14, 32'd0);
		send_request(ctht_pkg::MODE_REMOVE, 32'd7, 32'd0);
		send_request(ctht_pkg::MODE_GET, 32'd7, 32'd0);
		for (int i = 0; i < 4; i++)
			send_request(ctht_pkg::MODE_PUT, 32'(21 * i + 3), 32'(i + 9));
		send_request(ctht_pkg::MODE_PUT, 32'd100, 32'hA5A5_A5A5);
		send_request(ctht_pkg::MODE_PUT, 32'd0, 32'd0);
		send_request(ctht_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'd0);
		send_request(ctht_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'd0);
		send_request(ctht_pkg::MODE_CHANGE, 32'd99, 32'h7);
		send_request(ctht_pkg::MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
	endtask

	task automatic test_receiver_hold();
		hold_cycles = 400;
		random_traffic(25);
	endtask

	task automatic test_sender_pause();
		random_traffic(30);
		drain_results();
		random_traffic(30);
	endtask

	task automatic test_size_sweep();
		write_size(ctht_pkg::idx_t'(13));
		random_traffic(250);
		write_size(11'h7FF);
		random_traffic(220);
		write_size(ctht_pkg::idx_t'(1024));
		random_traffic(200);
		write_size(ctht_pkg::idx_t'(797));
		random_traffic(150);
		write_size(ctht_pkg::idx_t'(5));
		idle_on = 1'b0;
		random_traffic(200);
	endtask

	// response side stalls: random bursts, plus the long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else if (idle_left > 0) begin
			idle_left <= idle_left - 1;
			rsp.ready <= 1'b0;
		end else if (idle_on && rsp.ready && $urandom_range(0, 5) == 0) begin
			idle_left <= $urandom_range(0, 4);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.status = rsp.status;
			got.data_out = rsp.data_out;
			got.used_count = rsp.used_count;
			results_seen++;
			if (got.status == ctht_pkg::ST_FULL) full_hits++;
			if (got.status == ctht_pkg::ST_NOT_FOUND) miss_hits++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d data %h used %0d",
						got.status, got.data_out, got.used_count);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: exp st %0d data %h used %0d, got st %0d data %h used %0d",
							results_seen, want.status, want.data_out, want.used_count,
							got.status, got.data_out, got.used_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("tb_chained_hash_table_engine failed");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.mode = ctht_pkg::MODE_GET;
		req.key = '0;
		req.data_in = '0;
		cfg.valid = 1'b0;
		cfg.table_size = ctht_pkg::RESET_SIZE;
		rsp.ready = 1'b1;
		rebuild_table(ctht_pkg::RESET_SIZE);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_size();
		test_directed();
		test_receiver_hold();
		test_sender_pause();
		test_size_sweep();
		drain_results();
		repeat (200) @(posedge clk);
		mismatches += pending_results.size();
		$display("covered %0d requests, %0d results (%0d pool full, %0d not found)",
			items_sent, results_seen, full_hits, miss_hits);
		$display("table sizes 797, 7 (from 0 and 5), 13, 1024 (from 2047 and 1024)");
		if (mismatches == 0)
			$display("tb_chained_hash_table_engine passed");
		else
			$display("tb_chained_hash_table_engine failed");
		$finish;
	end

endmodule

FILE: sim.f
design/ctht_pkg.sv
design/ctht_req_if.sv
design/ctht_rsp_if.sv
design/ctht_cfg_if.sv
design/ctht_mod.sv
design/ctht_core.sv
design/chained_hash_table_engine.sv
tb/tb_chained_hash_table_engine.sv
